FILE: src/assert_macros.svh
// Assertion macros shared by the ring buffer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on clk_i and disabled while rst_ni is low.
`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked on clk_i and disabled while rst_ni is low.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: src/uartrb_pkg.sv
// Shared types and constants of the receive ring buffer.
package uartrb_pkg;

  localparam int DATA_W   = 8;   // byte width
  localparam int LEN_W    = 11;  // length, level and size width
  localparam int GSTART_W = 10;  // grant start index width
  localparam int APB_DW   = 32;  // config data width
  localparam int APB_AW   = 3;   // config byte address width

  // Register index, taken from paddr[2]
  localparam logic REG_BUF_SIZE = 1'b0;

  typedef enum logic [1:0] {
    OP_PUSH   = 2'd0,
    OP_POP    = 2'd1,
    OP_DMA_WR = 2'd2,
    OP_DMA_RD = 2'd3
  } op_e;

  // Controller to datapath
  typedef struct packed {
    logic clear;     // clearing pass: write zero at sweep address
    logic exec;      // input word accepted, update ring state
    logic load_now;  // load result register from this cycle's op
    logic load_pop;  // load result register with RAM read data
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic pop_hit;     // incoming word is a pop on a non-empty ring
    logic clear_last;  // sweep is at the last entry
  } stat_t;

endpackage

FILE: src/uartrb_if.sv
// Input and result channel interfaces of the receive ring buffer.
interface uartrb_in_if import uartrb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        op;
  logic [DATA_W-1:0] rx_byte;
  logic [LEN_W-1:0]  length;

  modport source (output valid, output op, output rx_byte, output length, input ready);
  modport sink   (input valid, input op, input rx_byte, input length, output ready);
endinterface

interface uartrb_out_if import uartrb_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [DATA_W-1:0]   read_byte;
  logic                read_valid;
  logic [GSTART_W-1:0] grant_start;
  logic [LEN_W-1:0]    grant_count;
  logic [LEN_W-1:0]    fill_level;
  logic                overrun_full;

  modport source (output valid, output read_byte, output read_valid, output grant_start,
                  output grant_count, output fill_level, output overrun_full, input ready);
  modport sink   (input valid, input read_byte, input read_valid, input grant_start,
                  input grant_count, input fill_level, input overrun_full, output ready);
endinterface

FILE: src/uartrb_ram.sv
// Generic single-write, single-read RAM with registered read data.
module uartrb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/uartrb_ctrl.sv
// Sequencer of the ring buffer: clearing pass, op issue and result handshake.
module uartrb_ctrl import uartrb_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_READ  = 2'd2;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       accept;
  logic       load;

  // take a word in the run state when the result register is free or drains this cycle
  assign in_ready_o = (state_q == ST_RUN) && (!out_valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;

  assign cmd_o.clear    = (state_q == ST_CLEAR);
  assign cmd_o.exec     = accept;
  assign cmd_o.load_now = accept && !stat_i.pop_hit;
  assign cmd_o.load_pop = (state_q == ST_READ);

  assign load = cmd_o.load_now || cmd_o.load_pop;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (stat_i.clear_last) begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if (accept && stat_i.pop_hit) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        state_d = ST_RUN;
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  // result register valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

FILE: src/uartrb_dp.sv
// Datapath of the ring buffer: indices, level, size register, byte store, result.
module uartrb_dp import uartrb_pkg::*; #(
  parameter int DEPTH = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cmd_t                cmd_i,
  output stat_t               stat_o,
  input  logic                cfg_we_i,
  input  logic [LEN_W-1:0]    cfg_size_i,
  output logic [LEN_W-1:0]    size_o,
  input  logic [1:0]          op_i,
  input  logic [DATA_W-1:0]   rx_byte_i,
  input  logic [LEN_W-1:0]    length_i,
  output logic [DATA_W-1:0]   read_byte_o,
  output logic                read_valid_o,
  output logic [GSTART_W-1:0] grant_start_o,
  output logic [LEN_W-1:0]    grant_count_o,
  output logic [LEN_W-1:0]    fill_level_o,
  output logic                overrun_full_o
);

  localparam int IW      = $clog2(DEPTH);
  localparam int CW      = (IW > LEN_W ? IW : LEN_W) + 1;
  localparam int LenMax  = (1 << LEN_W) - 1;
  localparam int SizeMax = DEPTH < LenMax ? DEPTH : LenMax;
  localparam int SizeRst = DEPTH < 1024 ? DEPTH : 1024;
  localparam logic [LEN_W-1:0] SizeMaxV = LEN_W'(SizeMax);
  localparam logic [LEN_W-1:0] SizeRstV = LEN_W'(SizeRst);
  localparam logic [IW-1:0]    ClrLast  = IW'(DEPTH - 1);

  logic [LEN_W-1:0] size_q, level_q, level_d;
  logic [IW-1:0]    wr_idx_q, wr_idx_d, rd_idx_q, rd_idx_d, clr_addr_q;
  logic             full_q, full_d;
  logic [LEN_W-1:0] cfg_size;

  logic [CW-1:0] sz, lvl, wr, rd, len_raw, len_sat, cnt, base, step, sum, adv, lvl_len;
  logic [CW-1:0] gstart;
  logic [DATA_W-1:0] ram_rdata;
  logic              ram_we;
  logic [IW-1:0]     ram_waddr;
  logic [DATA_W-1:0] ram_wdata;

  logic [DATA_W-1:0]   rbyte_q;
  logic                rvalid_q;
  logic [GSTART_W-1:0] gstart_q;
  logic [LEN_W-1:0]    gcount_q, lvl_out_q;
  logic                full_out_q;

  // size write: zero reads as one, above the built depth as the depth
  always_comb begin
    cfg_size = cfg_size_i;
    if (cfg_size_i == '0) begin
      cfg_size = LEN_W'(1);
    end else if (cfg_size_i > SizeMaxV) begin
      cfg_size = SizeMaxV;
    end
  end

  assign sz      = CW'(size_q);
  assign lvl     = CW'(level_q);
  assign wr      = CW'(wr_idx_q);
  assign rd      = CW'(rd_idx_q);
  assign len_raw = CW'(length_i);
  assign len_sat = (len_raw > sz) ? sz : len_raw;
  assign cnt     = (len_sat < lvl) ? len_sat : lvl;
  assign lvl_len = lvl + len_sat;
  assign gstart  = (op_i == OP_DMA_RD) ? rd : '0;

  assign stat_o.pop_hit    = (op_i == OP_POP) && (level_q != '0);
  assign stat_o.clear_last = (clr_addr_q == ClrLast);

  // shared index advance: one add, one compare, one subtract
  always_comb begin
    case (op_e'(op_i))
      OP_PUSH:   begin base = wr; step = CW'(1); end
      OP_POP:    begin base = rd; step = CW'(1); end
      OP_DMA_WR: begin base = wr; step = len_sat; end
      default:   begin base = rd; step = cnt;     end
    endcase
  end

  assign sum = base + step;
  assign adv = (sum >= sz) ? (sum - sz) : sum;

  // ring state update per op
  always_comb begin
    wr_idx_d = wr_idx_q;
    rd_idx_d = rd_idx_q;
    full_d   = full_q;
    level_d  = level_q;
    case (op_e'(op_i))
      OP_PUSH: begin
        wr_idx_d = adv[IW-1:0];
        if (full_q) begin
          rd_idx_d = adv[IW-1:0];
        end else begin
          level_d = LEN_W'(lvl + CW'(1));
          full_d  = ((lvl + CW'(1)) == sz);
        end
      end
      OP_POP: begin
        if (level_q != '0) begin
          rd_idx_d = adv[IW-1:0];
          full_d   = 1'b0;
          level_d  = LEN_W'(lvl - CW'(1));
        end
      end
      OP_DMA_WR: begin
        wr_idx_d = adv[IW-1:0];
        if (lvl_len >= sz) begin
          full_d   = 1'b1;
          rd_idx_d = adv[IW-1:0];
          level_d  = size_q;
        end else begin
          level_d = LEN_W'(lvl_len);
        end
      end
      default: begin
        rd_idx_d = adv[IW-1:0];
        level_d  = LEN_W'(lvl - cnt);
        if (cnt != '0) begin
          full_d = 1'b0;
        end
      end
    endcase
  end

  // ring control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q     <= SizeRstV;
      wr_idx_q   <= '0;
      rd_idx_q   <= '0;
      full_q     <= 1'b0;
      level_q    <= '0;
      clr_addr_q <= '0;
    end else begin
      if (cmd_i.clear) begin
        clr_addr_q <= clr_addr_q + IW'(1);
      end
      if (cfg_we_i) begin
        size_q   <= cfg_size;
        wr_idx_q <= '0;
        rd_idx_q <= '0;
        full_q   <= 1'b0;
        level_q  <= '0;
      end else if (cmd_i.exec) begin
        wr_idx_q <= wr_idx_d;
        rd_idx_q <= rd_idx_d;
        full_q   <= full_d;
        level_q  <= level_d;
      end
    end
  end

  // byte store: sweep writes zeros after reset, push writes the byte
  assign ram_we    = cmd_i.clear || (cmd_i.exec && (op_i == OP_PUSH));
  assign ram_waddr = cmd_i.clear ? clr_addr_q : wr_idx_q;
  assign ram_wdata = cmd_i.clear ? '0 : rx_byte_i;

  uartrb_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (cmd_i.exec && stat_o.pop_hit),
    .raddr_i (rd_idx_q),
    .rdata_o (ram_rdata)
  );

  // result register; a pop takes state from the regs already updated
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_now) begin
      rbyte_q    <= '0;
      rvalid_q   <= 1'b0;
      gstart_q   <= gstart[GSTART_W-1:0];
      gcount_q   <= (op_i == OP_DMA_RD) ? LEN_W'(cnt) : '0;
      lvl_out_q  <= level_d;
      full_out_q <= full_d;
    end else if (cmd_i.load_pop) begin
      rbyte_q    <= ram_rdata;
      rvalid_q   <= 1'b1;
      gstart_q   <= '0;
      gcount_q   <= '0;
      lvl_out_q  <= level_q;
      full_out_q <= full_q;
    end
  end

  assign size_o         = size_q;
  assign read_byte_o    = rbyte_q;
  assign read_valid_o   = rvalid_q;
  assign grant_start_o  = gstart_q;
  assign grant_count_o  = gcount_q;
  assign fill_level_o   = lvl_out_q;
  assign overrun_full_o = full_out_q;

endmodule

FILE: src/uart_rx_ring_buffer_overwrite.sv
// Top level of the serial receive ring buffer with overwrite-oldest policy.
// Each word gives one result word through a result register and is taken while that
// register is empty or being drained; push, DMA write done and DMA read grant words
// can follow one another every cycle. A pop that returns a byte holds the input while
// the registered read port of the byte store delivers it. After reset the byte store
// is swept to zero, one entry a cycle, and no word is taken until the sweep reaches
// the last entry; config writes are taken throughout. buffer_size sits at byte
// address 0 of the APB port; writing it empties the ring.
`include "assert_macros.svh"

module uart_rx_ring_buffer_overwrite import uartrb_pkg::*; #(
  parameter int DEPTH = 1024
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  uartrb_in_if.sink         req_i,
  uartrb_out_if.source      rsp_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  cmd_t             cmd;
  stat_t            stat;
  logic             cfg_we;
  logic [LEN_W-1:0] size;

  // APB decode: one register, no wait states
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[2] == REG_BUF_SIZE);
  assign prdata = (paddr[2] == REG_BUF_SIZE) ? {{(APB_DW - LEN_W){1'b0}}, size} : '0;

  uartrb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  uartrb_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .cfg_we_i       (cfg_we),
    .cfg_size_i     (pwdata[LEN_W-1:0]),
    .size_o         (size),
    .op_i           (req_i.op),
    .rx_byte_i      (req_i.rx_byte),
    .length_i       (req_i.length),
    .read_byte_o    (rsp_o.read_byte),
    .read_valid_o   (rsp_o.read_valid),
    .grant_start_o  (rsp_o.grant_start),
    .grant_count_o  (rsp_o.grant_count),
    .fill_level_o   (rsp_o.fill_level),
    .overrun_full_o (rsp_o.overrun_full)
  );

  // a word is never taken while a result sits stalled
  `ASSERT_IMPL(a_no_accept_on_stall, req_i.valid && req_i.ready, !(rsp_o.valid && !rsp_o.ready))
  // reported level never exceeds the ring size
  `ASSERT_IMPL(a_level_in_range, rsp_o.valid, rsp_o.fill_level <= size)
  // a full flag always comes with a full level
  `ASSERT_IMPL(a_full_level, rsp_o.valid && rsp_o.overrun_full, rsp_o.fill_level == size)
  // a pop that hits blocks the input for its RAM read cycle
  `ASSERT_NEXT(a_pop_blocks, req_i.valid && req_i.ready && stat.pop_hit, !req_i.ready)

endmodule

FILE: test/tb_uart_rx_ring_buffer_overwrite.sv
`timescale 1ns / 100ps
// Testbench of the receive ring buffer: directed rows, then random words checked by a ring model.
module tb_uart_rx_ring_buffer_overwrite;
  import uartrb_pkg::*;

  localparam int RING_DEPTH  = 1024;
  localparam int LIMIT_CYC   = 200000;
  localparam int HOLD_CYC    = 60;
  localparam int PHASE_ITEMS = 66;
  localparam int NUM_PHASES  = 9;
  localparam int END_CYC     = 8;
  localparam int MAX_REPORTS = 10;

  // paddr[2] selects the register; the unused slot must be ignored
  localparam logic [APB_AW-1:0] ADDR_BUF_SIZE = {REG_BUF_SIZE, 2'b00};
  localparam logic [APB_AW-1:0] ADDR_UNUSED   = {~REG_BUF_SIZE, 2'b00};

  typedef struct packed {
    logic [DATA_W-1:0]   read_byte;
    logic                read_valid;
    logic [GSTART_W-1:0] grant_start;
    logic [LEN_W-1:0]    grant_count;
    logic [LEN_W-1:0]    fill_level;
    logic                overrun_full;
  } ring_rsp_t;

  // One row of the directed sequence: a config write or an input word
  typedef struct {
    bit                is_cfg;
    logic [APB_AW-1:0] addr;
    logic [APB_DW-1:0] wdata;
    op_e               op;
    logic [DATA_W-1:0] rx;
    logic [LEN_W-1:0]  len;
    bit                has_lit;
    ring_rsp_t         lit;
  } dir_row_t;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  uartrb_in_if  req_if ();
  uartrb_out_if rsp_if ();

  uart_rx_ring_buffer_overwrite u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_if),
    .rsp_o   (rsp_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #10 clk_i = ~clk_i;

  // Ring model state
  logic [DATA_W-1:0]   ring_mem [RING_DEPTH];
  logic [GSTART_W-1:0] wr_ptr;
  logic [GSTART_W-1:0] rd_ptr;
  logic                ring_full;
  logic [LEN_W-1:0]    ring_size;

  ring_rsp_t pending_rsp [$];
  dir_row_t  dir_rows [$];

  bit idle_on;
  bit start_hold;
  bit hold_off;
  int n_items, n_results, n_errors;
  int n_pop_bytes, n_overwrites, n_dma_overruns, n_sizes;

  // ---------------------------------------------------------------------------
  // Ring model
  // ---------------------------------------------------------------------------
  function automatic logic [LEN_W-1:0] ring_level();
    if (wr_ptr == rd_ptr) return ring_full ? ring_size : '0;
    if (wr_ptr > rd_ptr) return LEN_W'(wr_ptr - rd_ptr);
    return ring_size - LEN_W'(rd_ptr - wr_ptr);
  endfunction

  // step never exceeds the size, so one subtraction wraps
  function automatic logic [GSTART_W-1:0] ring_adv(logic [GSTART_W-1:0] idx,
                                                   logic [LEN_W-1:0] step);
    int n;
    n = int'(idx) + int'(step);
    if (n >= int'(ring_size)) n -= int'(ring_size);
    return GSTART_W'(n);
  endfunction

  function automatic ring_rsp_t ring_step(op_e op, logic [DATA_W-1:0] rx,
                                          logic [LEN_W-1:0] len_in);
    ring_rsp_t        r;
    logic [LEN_W-1:0] len;
    logic [LEN_W-1:0] lvl;
    bit               was_full;
    r   = '0;
    len = (len_in > ring_size) ? ring_size : len_in;
    case (op)
      OP_PUSH: begin
        was_full         = ring_full;
        ring_mem[wr_ptr] = rx;
        wr_ptr           = ring_adv(wr_ptr, LEN_W'(1));
        if (was_full) begin
          // oldest byte lost, read side follows the write side
          rd_ptr = wr_ptr;
          n_overwrites++;
        end else if (wr_ptr == rd_ptr) begin
          ring_full = 1'b1;
        end
      end
      OP_POP: begin
        if (ring_level() != 0) begin
          r.read_byte  = ring_mem[rd_ptr];
          r.read_valid = 1'b1;
          rd_ptr       = ring_adv(rd_ptr, LEN_W'(1));
          ring_full    = 1'b0;
          n_pop_bytes++;
        end
      end
      OP_DMA_WR: begin
        lvl    = ring_level();
        wr_ptr = ring_adv(wr_ptr, len);
        if (int'(lvl) + int'(len) >= int'(ring_size)) begin
          ring_full = 1'b1;
          rd_ptr    = wr_ptr;
          n_dma_overruns++;
        end
      end
      default: begin
        lvl           = ring_level();
        r.grant_count = (len < lvl) ? len : lvl;
        r.grant_start = rd_ptr;
        rd_ptr        = ring_adv(rd_ptr, r.grant_count);
        if (r.grant_count != 0) ring_full = 1'b0;
      end
    endcase
    r.fill_level   = ring_level();
    r.overrun_full = ring_full;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Directed rows
  // ---------------------------------------------------------------------------
  function automatic dir_row_t row_lit(op_e op, logic [DATA_W-1:0] rx, logic [LEN_W-1:0] len,
                                       ring_rsp_t lit);
    dir_row_t d;
    d.is_cfg  = 1'b0;
    d.addr    = ADDR_BUF_SIZE;
    d.wdata   = '0;
    d.op      = op;
    d.rx      = rx;
    d.len     = len;
    d.has_lit = 1'b1;
    d.lit     = lit;
    return d;
  endfunction

  function automatic dir_row_t row_item(op_e op, logic [DATA_W-1:0] rx, logic [LEN_W-1:0] len);
    dir_row_t d;
    d         = row_lit(op, rx, len, '0);
    d.has_lit = 1'b0;
    return d;
  endfunction

  function automatic dir_row_t row_cfg(logic [APB_AW-1:0] addr, logic [APB_DW-1:0] data);
    dir_row_t d;
    d        = row_item(OP_PUSH, '0, '0);
    d.is_cfg = 1'b1;
    d.addr   = addr;
    d.wdata  = data;
    return d;
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------
  task automatic send_item(input op_e op, input logic [DATA_W-1:0] rx,
                           input logic [LEN_W-1:0] len, input bit has_lit, input ring_rsp_t lit);
    int        gap;
    ring_rsp_t want;
    gap = idle_on ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid   <= 1'b1;
    req_if.op      <= op;
    req_if.rx_byte <= rx;
    req_if.length  <= len;
    do @(posedge clk_i); while (!req_if.ready);
    want = ring_step(op, rx, len);
    pending_rsp.push_back(has_lit ? lit : want);
    n_items++;
  endtask

  // Register writes only once every pending word has come back
  task automatic cfg_write(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
    logic [LEN_W-1:0] v;
    req_if.valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr[2] == REG_BUF_SIZE) begin
      v = data[LEN_W-1:0];
      if (v == 0) v = LEN_W'(1);
      if (v > RING_DEPTH) v = LEN_W'(RING_DEPTH);
      ring_size = v;
      wr_ptr    = '0;
      rd_ptr    = '0;
      ring_full = 1'b0;
      n_sizes++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random stalls plus one long hold-off
  // ---------------------------------------------------------------------------
  initial begin
    int gap;
    rsp_if.ready <= 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      gap = idle_on ? $urandom_range(0, 4) : 0;
      if (gap > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      while (hold_off) begin
        rsp_if.ready <= 1'b0;
        @(posedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk_i); while (!(rsp_if.valid && rsp_if.ready));
    end
  end

  initial begin
    hold_off = 1'b0;
    wait (start_hold);
    @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (HOLD_CYC) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  task automatic report_mismatch(input string what, input ring_rsp_t want, input ring_rsp_t got);
    n_errors++;
    if (n_errors <= MAX_REPORTS) begin
      $display("MISMATCH %s: exp byte=%02h vld=%0d gs=%0d gc=%0d lvl=%0d full=%0d",
               what, want.read_byte, want.read_valid, want.grant_start, want.grant_count,
               want.fill_level, want.overrun_full);
      $display("  got byte=%02h vld=%0d gs=%0d gc=%0d lvl=%0d full=%0d",
               got.read_byte, got.read_valid, got.grant_start, got.grant_count,
               got.fill_level, got.overrun_full);
    end
  endtask

  // Compare each accepted result word with the oldest pending one
  always @(posedge clk_i) begin : rsp_check
    ring_rsp_t got;
    ring_rsp_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      got.read_byte    = rsp_if.read_byte;
      got.read_valid   = rsp_if.read_valid;
      got.grant_start  = rsp_if.grant_start;
      got.grant_count  = rsp_if.grant_count;
      got.fill_level   = rsp_if.fill_level;
      got.overrun_full = rsp_if.overrun_full;
      n_results++;
      if (pending_rsp.size() == 0) begin
        report_mismatch("no word pending", '0, got);
      end else begin
        want = pending_rsp.pop_front();
        if (got.read_byte !== want.read_byte || got.read_valid !== want.read_valid ||
            got.grant_start !== want.grant_start || got.grant_count !== want.grant_count ||
            got.fill_level !== want.fill_level || got.overrun_full !== want.overrun_full)
          report_mismatch("field", want, got);
      end
    end
  end

  // Watchdog
  initial begin
    int cyc;
    cyc = 0;
    while (cyc < LIMIT_CYC) begin
      @(posedge clk_i);
      cyc++;
    end
    $display("timeout after %0d cycles", LIMIT_CYC);
    $display("tb_uart_rx_ring_buffer_overwrite: done, errors");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    int               r;
    logic [LEN_W-1:0] v;
    logic [LEN_W-1:0] len;
    op_e              op;

    rst_ni         <= 1'b0;
    req_if.valid   <= 1'b0;
    req_if.op      <= OP_PUSH;
    req_if.rx_byte <= '0;
    req_if.length  <= '0;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    idle_on    = 1'b1;
    start_hold = 1'b0;
    foreach (ring_mem[i]) ring_mem[i] = '0;
    wr_ptr    = '0;
    rd_ptr    = '0;
    ring_full = 1'b0;
    ring_size = LEN_W'(RING_DEPTH);

    // empty ring at reset size, then saturation and overrun
    dir_rows.push_back(row_lit(OP_POP, 8'h00, 11'd0, '0));
    dir_rows.push_back(row_lit(OP_DMA_RD, 8'h00, 11'd1024, '0));
    dir_rows.push_back(row_lit(OP_PUSH, 8'hFF, 11'd0,
                               ring_rsp_t'{8'h00, 1'b0, 10'd0, 11'd0, 11'd1, 1'b0}));
    dir_rows.push_back(row_lit(OP_PUSH, 8'h00, 11'd0,
                               ring_rsp_t'{8'h00, 1'b0, 10'd0, 11'd0, 11'd2, 1'b0}));
    dir_rows.push_back(row_lit(OP_POP, 8'h00, 11'd0,
                               ring_rsp_t'{8'hFF, 1'b1, 10'd0, 11'd0, 11'd1, 1'b0}));
    dir_rows.push_back(row_item(OP_DMA_WR, 8'h00, 11'h7FF));
    dir_rows.push_back(row_item(OP_PUSH, 8'hA5, 11'd0));
    dir_rows.push_back(row_item(OP_DMA_RD, 8'h00, 11'h7FF));
    dir_rows.push_back(row_item(OP_POP, 8'h00, 11'd0));
    // size 3: wrap and overwrite of the oldest byte
    dir_rows.push_back(row_cfg(ADDR_BUF_SIZE, 32'd3));
    dir_rows.push_back(row_item(OP_PUSH, 8'h01, 11'd0));
    dir_rows.push_back(row_item(OP_PUSH, 8'h02, 11'd0));
    dir_rows.push_back(row_item(OP_PUSH, 8'h03, 11'd0));
    dir_rows.push_back(row_item(OP_PUSH, 8'h04, 11'd0));
    dir_rows.push_back(row_item(OP_POP, 8'h00, 11'd0));
    dir_rows.push_back(row_item(OP_DMA_WR, 8'h00, 11'd0));
    dir_rows.push_back(row_item(OP_DMA_RD, 8'h00, 11'd1));
    // size written as zero acts as one entry
    dir_rows.push_back(row_cfg(ADDR_BUF_SIZE, 32'd0));
    dir_rows.push_back(row_lit(OP_PUSH, 8'h7E, 11'd0,
                               ring_rsp_t'{8'h00, 1'b0, 10'd0, 11'd0, 11'd1, 1'b1}));
    dir_rows.push_back(row_item(OP_PUSH, 8'h81, 11'd0));
    dir_rows.push_back(row_lit(OP_POP, 8'h00, 11'd0,
                               ring_rsp_t'{8'h81, 1'b1, 10'd0, 11'd0, 11'd0, 1'b0}));
    // write to the unused slot leaves size and ring alone
    dir_rows.push_back(row_cfg(ADDR_UNUSED, 32'd5));
    dir_rows.push_back(row_item(OP_PUSH, 8'h3C, 11'd0));
    // oversize value clamps to the full depth
    dir_rows.push_back(row_cfg(ADDR_BUF_SIZE, 32'hFFFF_FFFF));
    dir_rows.push_back(row_item(OP_DMA_WR, 8'h00, 11'd1023));
    dir_rows.push_back(row_item(OP_PUSH, 8'h55, 11'd0));
    dir_rows.push_back(row_item(OP_DMA_RD, 8'h00, 11'd2));
    // upper bits above the size field are dropped
    dir_rows.push_back(row_cfg(ADDR_BUF_SIZE, 32'h0000_0805));
    dir_rows.push_back(row_item(OP_DMA_WR, 8'h00, 11'd7));
    dir_rows.push_back(row_item(OP_DMA_RD, 8'h00, 11'd3));

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg)
        cfg_write(dir_rows[i].addr, dir_rows[i].wdata);
      else
        send_item(dir_rows[i].op, dir_rows[i].rx, dir_rows[i].len,
                  dir_rows[i].has_lit, dir_rows[i].lit);
    end

    // Random phases, one size setting each; small sizes dominate
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0:       v = 11'd1024;
        1:       v = 11'd0;
        2:       v = 11'd2;
        3:       v = 11'd3;
        4:       v = LEN_W'($urandom_range(4, 16));
        5:       v = LEN_W'($urandom_range(17, 64));
        6:       v = 11'd1023;
        7:       v = 11'd1500;
        default: v = LEN_W'($urandom_range(1, 16));
      endcase
      cfg_write(ADDR_BUF_SIZE, ($urandom() & ~32'h7FF) | APB_DW'(v));
      if (p == 2) start_hold = 1'b1;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (k % 22 == 0) idle_on = ($urandom_range(0, 3) != 0);
        r = $urandom_range(0, 19);
        if (r < 8)       op = OP_PUSH;
        else if (r < 13) op = OP_POP;
        else if (r < 16) op = OP_DMA_WR;
        else             op = OP_DMA_RD;
        r = $urandom_range(0, 9);
        if (r < 5)       len = LEN_W'($urandom_range(0, ring_size));
        else if (r < 8)  len = LEN_W'($urandom_range(0, 3));
        else if (r == 8) len = LEN_W'($urandom_range(0, 2047));
        else             len = ring_size;
        send_item(op, DATA_W'($urandom_range(0, 255)), len, 1'b0, '0);
      end
    end

    // Drain and let stray words show up
    req_if.valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk_i);
    repeat (END_CYC) @(posedge clk_i);

    $display("run: %0d words in, %0d results, %0d size writes, %0d bytes popped",
             n_items, n_results, n_sizes, n_pop_bytes);
    $display("run: %0d push overwrites, %0d dma overruns, %0d mismatches",
             n_overwrites, n_dma_overruns, n_errors);
    if (n_errors == 0) begin
      $display("tb_uart_rx_ring_buffer_overwrite: done, clean");
    end else begin
      $display("tb_uart_rx_ring_buffer_overwrite: done, errors");
    end
    $finish;
  end

endmodule
